// File: sv/gvdc_pkg.sv
// ----------------------------------------------------------------------------
// gvdc_pkg: shared types and constants of the gap voltage drop classifier
// Word formats, field widths, register indexes, plan codes and the sizes
// used by the serial divider.
// ----------------------------------------------------------------------------
package gvdc_pkg;

  localparam int unsigned READING_W  = 12;
  localparam int unsigned DROP_W     = 15;
  localparam int unsigned AGE_W      = 16;
  localparam int unsigned PLAN_W     = 2;
  localparam int unsigned CFG_W      = 16;
  localparam int unsigned CFG_IDX_W  = 2;

  // The divider keeps a quotient of up to QUOT_W bits and a remainder as wide
  // as a reading, so its dividend is the two together.
  localparam int unsigned QUOT_W     = 15;
  localparam int unsigned DIVIDEND_W = READING_W + QUOT_W;

  localparam logic [DROP_W-1:0] DROP_FULL = 15'd25600;
  localparam logic [AGE_W-1:0]  AGE_MAX   = 16'hFFFF;

  localparam logic [CFG_IDX_W-1:0] CFG_BAND_LOW   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_HIGH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STALE_LIM  = 2'd2;

  localparam logic [DROP_W-1:0] BAND_LOW_RST   = 15'd2560;
  localparam logic [DROP_W-1:0] BAND_HIGH_RST  = 15'd7680;
  localparam logic [AGE_W-1:0]  STALE_LIM_RST  = 16'd500;

  localparam logic [PLAN_W-1:0] PLAN_ADVANCE = 2'd0;
  localparam logic [PLAN_W-1:0] PLAN_LOWER   = 2'd1;
  localparam logic [PLAN_W-1:0] PLAN_UPPER   = 2'd2;
  localparam logic [PLAN_W-1:0] PLAN_ABOVE   = 2'd3;

  typedef struct packed {
    logic                 cmd;
    logic [READING_W-1:0] reading_a;
    logic [READING_W-1:0] reading_b;
    logic                 hold_reference;
  } gvdc_in_t;

  typedef struct packed {
    logic [PLAN_W-1:0] plan;
    logic [DROP_W-1:0] drop_level;
    logic              stale;
  } gvdc_out_t;

endpackage

// File: sv/gvdc_ram.sv
// ----------------------------------------------------------------------------
// gvdc_ram: generic single-write, single-read RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module gvdc_ram #(
  parameter int unsigned WIDTH = 12,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/gvdc_div.sv
// ----------------------------------------------------------------------------
// gvdc_div: serial restoring divider
// Produces one quotient bit per cycle. The caller guarantees that the upper
// part of the dividend is below the divisor, so the quotient fits QUOT_W bits.
// ----------------------------------------------------------------------------
module gvdc_div import gvdc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [READING_W-1:0]  divisor_i,
  output logic [QUOT_W-1:0]     quotient_o,
  output logic                  done_o
);

  localparam int unsigned CNT_W = $clog2(QUOT_W + 1);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [READING_W-1:0] rem_q, rem_d;
  logic [QUOT_W-1:0]    dq_q, dq_d;
  logic [READING_W-1:0] dvs_q, dvs_d;
  logic [READING_W:0]   trial;
  logic [READING_W:0]   trial_sub;
  logic                 fits;

  always_comb begin
    trial     = {rem_q, dq_q[QUOT_W-1]};
    trial_sub = trial - {1'b0, dvs_q};
    fits      = trial >= {1'b0, dvs_q};
    busy_d    = busy_q;
    done_d    = 1'b0;
    cnt_d     = cnt_q;
    rem_d     = rem_q;
    dq_d      = dq_q;
    dvs_d     = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(QUOT_W);
      rem_d  = dividend_i[DIVIDEND_W-1:QUOT_W];
      dq_d   = dividend_i[QUOT_W-1:0];
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      // The remainder stays below the divisor, so the difference fits.
      rem_d = fits ? trial_sub[READING_W-1:0] : trial[READING_W-1:0];
      dq_d  = {dq_q[QUOT_W-2:0], fits};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dq_q  <= dq_d;
    dvs_q <= dvs_d;
  end

  assign quotient_o = dq_q;
  assign done_o     = done_q;

`ifndef NO_ASSERTIONS
  a_start_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider started while busy");
  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> rem_q < dvs_q)
    else $error("divider remainder reached the divisor");
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q))
    else $error("divider done without a running division");
`endif

endmodule

// File: sv/gap_voltage_drop_classifier.sv
// ----------------------------------------------------------------------------
// gap_voltage_drop_classifier: moving-average gap voltage drop classifier
// Averages reading pairs over a window, tracks a reference level and
// classifies the relative voltage drop against a configured band.
// ----------------------------------------------------------------------------
// Usage:
// An input word carries either a one-microsecond tick (cmd = 0) or a pair of
// gap voltage readings (cmd = 1). Each accepted word gives exactly one output
// word with the plan, the drop level and the stale flag.
// A word moves when valid is high and stall is low. The input channel stalls
// while a word is being worked on, so one word is in flight at a time.
// The sequencer steps from idle through the window update, the average and the
// drop start, waits for the divider only when the drop is nonzero, then writes
// the output; the drop is zero without a division when the reference is zero
// or not above the average. The window average comes from a constant
// reciprocal multiply; the drop ratio uses the serial divider. A new word is
// taken once the result is registered and the sequencer is back in idle.
// The result sits in an output register; if the receiver stalls, the next
// word is still worked on and waits at the end until that register frees.
// Reset clears the window through its fill flag, the age, the reference and
// sets the band and stale limit registers to their defaults. Configuration is
// written through cfg_we_i, cfg_idx_i and cfg_wdata_i; the user must write it
// only while the block is idle, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
module gap_voltage_drop_classifier import gvdc_pkg::*; #(
  parameter int unsigned WINDOW_LEN = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  gvdc_in_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output gvdc_out_t            out_data_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i
);

  localparam int unsigned SLOT_W  = $clog2(WINDOW_LEN);
  localparam int unsigned TOTAL_W = $clog2(4095 * WINDOW_LEN + 1);

  // The window average is a multiply by a rounded-up reciprocal. With this
  // shift it is exact for every total below 2**TOTAL_W.
  localparam int unsigned AVG_SH  = TOTAL_W + $clog2(WINDOW_LEN);
  localparam int unsigned RECIP_W = TOTAL_W + 2;
  localparam int unsigned PROD_W  = TOTAL_W + RECIP_W;
  localparam logic [RECIP_W-1:0] AVG_RECIP =
      RECIP_W'(((64'd1 << AVG_SH) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_RD    = 6'b000010,
    S_AVG   = 6'b000100,
    S_SDROP = 6'b001000,
    S_WDROP = 6'b010000,
    S_OUT   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [DROP_W-1:0]    band_low_q, band_high_q;
  logic [AGE_W-1:0]     stale_lim_q;

  logic [SLOT_W-1:0]    slot_q, slot_d;
  logic                 full_q, full_d;
  logic [TOTAL_W-1:0]   total_q, total_d;
  logic [READING_W-1:0] ref_q, ref_d;
  logic [AGE_W-1:0]     age_q, age_d;

  logic                 cmd_q, hold_q;
  logic [READING_W-1:0] pair_q, avg_q, avg_d;
  logic [DROP_W-1:0]    drop_q, drop_d;

  logic                 out_valid_q, out_valid_d;
  gvdc_out_t            out_q, out_d;

  logic                 in_acc;
  logic [READING_W:0]   pair_sum;
  logic [READING_W-1:0] ram_rdata, old_entry;
  logic                 ram_we;

  logic [PROD_W-1:0]    avg_prod;
  logic [READING_W-1:0] avg_now;

  logic                  div_start, div_done;
  logic [DIVIDEND_W-1:0] drop_num;
  logic [QUOT_W-1:0]     div_quot;
  logic                  drop_needed;

  logic                 out_free;
  logic                 below, above, upper, stale;
  logic [DROP_W-1:0]    dist_high, dist_low;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign pair_sum   = {1'b0, in_data_i.reading_a} + {1'b0, in_data_i.reading_b};

  assign ram_we    = (state_q == S_RD) && cmd_q;
  assign old_entry = full_q ? ram_rdata : '0;

  gvdc_ram #(
    .WIDTH(READING_W),
    .DEPTH(WINDOW_LEN)
  ) u_window (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(slot_q),
    .wdata_i(pair_q),
    .raddr_i(slot_q),
    .rdata_o(ram_rdata)
  );

  assign avg_prod = {{RECIP_W{1'b0}}, total_q} * {{TOTAL_W{1'b0}}, AVG_RECIP};
  assign avg_now  = avg_prod[AVG_SH +: READING_W];

  assign drop_needed = (ref_q != '0) && (avg_q < ref_q);
  assign drop_num    = {{(DIVIDEND_W-DROP_W){1'b0}}, DROP_FULL}
                     * {{(DIVIDEND_W-READING_W){1'b0}}, ref_q - avg_q};
  assign div_start   = (state_q == S_SDROP) && drop_needed;

  gvdc_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(drop_num),
    .divisor_i (ref_q),
    .quotient_o(div_quot),
    .done_o    (div_done)
  );

  // Classification of the finished drop against the band.
  always_comb begin
    dist_high = band_high_q - drop_q;
    dist_low  = drop_q - band_low_q;
    below     = drop_q < band_low_q;
    above     = drop_q > band_high_q;
    upper     = dist_high < dist_low;
    stale     = age_q > stale_lim_q;
    out_d.drop_level = drop_q;
    out_d.stale      = stale;
    if (below) begin
      out_d.plan = stale ? PLAN_LOWER : PLAN_ADVANCE;
    end else if (above) begin
      out_d.plan = PLAN_ABOVE;
    end else if (upper) begin
      out_d.plan = PLAN_UPPER;
    end else begin
      out_d.plan = PLAN_LOWER;
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    slot_d      = slot_q;
    full_d      = full_q;
    total_d     = total_q;
    ref_d       = ref_q;
    age_d       = age_q;
    avg_d       = avg_q;
    drop_d      = drop_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_RD;
        end
      end
      S_RD: begin
        if (cmd_q) begin
          total_d = total_q - {{(TOTAL_W-READING_W){1'b0}}, old_entry}
                  + {{(TOTAL_W-READING_W){1'b0}}, pair_q};
          if (slot_q == SLOT_W'(WINDOW_LEN - 1)) begin
            slot_d = '0;
            full_d = 1'b1;
          end else begin
            slot_d = slot_q + SLOT_W'(1);
          end
          age_d = '0;
        end else if (age_q != AGE_MAX) begin
          age_d = age_q + AGE_W'(1);
        end
        state_d = S_AVG;
      end
      S_AVG: begin
        avg_d = avg_now;
        if (!hold_q) begin
          ref_d = avg_now;
        end
        state_d = S_SDROP;
      end
      S_SDROP: begin
        if (drop_needed) begin
          state_d = S_WDROP;
        end else begin
          drop_d  = '0;
          state_d = S_OUT;
        end
      end
      S_WDROP: begin
        if (div_done) begin
          drop_d  = div_quot;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      slot_q      <= '0;
      full_q      <= 1'b0;
      total_q     <= '0;
      ref_q       <= '0;
      age_q       <= '0;
      out_valid_q <= 1'b0;
      band_low_q  <= BAND_LOW_RST;
      band_high_q <= BAND_HIGH_RST;
      stale_lim_q <= STALE_LIM_RST;
    end else begin
      state_q     <= state_d;
      slot_q      <= slot_d;
      full_q      <= full_d;
      total_q     <= total_d;
      ref_q       <= ref_d;
      age_q       <= age_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_BAND_LOW:  band_low_q  <= cfg_wdata_i[DROP_W-1:0];
          CFG_BAND_HIGH: band_high_q <= cfg_wdata_i[DROP_W-1:0];
          CFG_STALE_LIM: stale_lim_q <= cfg_wdata_i[AGE_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q  <= in_data_i.cmd;
      hold_q <= in_data_i.hold_reference;
      pair_q <= pair_sum[READING_W:1];
    end
    avg_q  <= avg_d;
    drop_q <= drop_d;
    if ((state_q == S_OUT) && out_free) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  a_slot_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q <= SLOT_W'(WINDOW_LEN - 1))
    else $error("window slot beyond the window length");
  a_drop_div_operands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WDROP) |-> (ref_q != '0) && (avg_q < ref_q))
    else $error("drop division with a reference not above the average");
  a_result_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT) && out_valid_q && out_stall_i |=> (state_q == S_OUT))
    else $error("result left the sequencer while the output word was held");
  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !full_q |-> total_q <= TOTAL_W'(4095) * TOTAL_W'(slot_q))
    else $error("window total exceeds the entries written so far");
`endif

endmodule

// File: tb/tb_gap_voltage_drop_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gap_voltage_drop_classifier: self-checking bench of the drop classifier
// Drives ticks and reading pairs through the valid/stall input channel and
// predicts each output word from a behavioral copy of the window, the
// reference and the age counter. Output words are checked in order against
// the predictions while both channels idle and stall at random. The band
// edges and the stale limit are moved between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_gap_voltage_drop_classifier;
  import gvdc_pkg::*;

  localparam int unsigned WIN_LEN      = 8;
  localparam int unsigned CYCLE_LIMIT  = 4_000_000;
  localparam int unsigned PHASE_WORDS  = 138;
  localparam int unsigned PHASE_COUNT  = 8;
  localparam int unsigned REPORT_LIMIT = 10;

  // Behavioral model of the classifier plus the queue of predicted words.
  class drop_scoreboard;
    logic [DROP_W-1:0]    band_low;
    logic [DROP_W-1:0]    band_high;
    logic [AGE_W-1:0]     stale_lim;
    logic [READING_W-1:0] win [WIN_LEN];
    int unsigned          slot;
    int unsigned          win_total;
    int unsigned          ref_lvl;
    int unsigned          age;
    gvdc_out_t            drop_results_q[$];
    int unsigned          errors;
    int unsigned          checked;
    int unsigned          readings;
    int unsigned          ticks;

    function new();
      band_low  = BAND_LOW_RST;
      band_high = BAND_HIGH_RST;
      stale_lim = STALE_LIM_RST;
      foreach (win[i]) win[i] = '0;
      slot      = 0;
      win_total = 0;
      ref_lvl   = 0;
      age       = 0;
      errors    = 0;
      checked   = 0;
      readings  = 0;
      ticks     = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_BAND_LOW:  band_low  = val[DROP_W-1:0];
        CFG_BAND_HIGH: band_high = val[DROP_W-1:0];
        CFG_STALE_LIM: stale_lim = val;
        default: ;
      endcase
    endfunction

    function void predict_word(gvdc_in_t w);
      int unsigned avg;
      int unsigned drop;
      int unsigned lo;
      int unsigned hi;
      logic        stale;
      gvdc_out_t   res;
      if (w.cmd) begin
        win[slot] = READING_W'((int'(w.reading_a) + int'(w.reading_b)) >> 1);
        slot = (slot + 1) % WIN_LEN;
        win_total = 0;
        foreach (win[i]) win_total += win[i];
        age = 0;
        readings++;
      end else begin
        if (age < int'(AGE_MAX)) age++;
        ticks++;
      end
      avg = win_total / WIN_LEN;
      if (!w.hold_reference) ref_lvl = avg;
      stale = (age > int'(stale_lim));
      if (ref_lvl == 0 || avg >= ref_lvl) drop = 0;
      else drop = (int'(DROP_FULL) * (ref_lvl - avg)) / ref_lvl;
      lo = band_low;
      hi = band_high;
      if (drop < lo) res.plan = stale ? PLAN_LOWER : PLAN_ADVANCE;
      else if (drop > hi) res.plan = PLAN_ABOVE;
      else if ((hi - drop) < (drop - lo)) res.plan = PLAN_UPPER;
      else res.plan = PLAN_LOWER;
      res.drop_level = DROP_W'(drop);
      res.stale      = stale;
      drop_results_q.push_back(res);
    endfunction

    function void check_word(gvdc_out_t got);
      gvdc_out_t exp_w;
      if (drop_results_q.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("ERROR: output word with nothing predicted: plan %0d drop %0d stale %0d",
                   got.plan, got.drop_level, got.stale);
        return;
      end
      exp_w = drop_results_q.pop_front();
      checked++;
      if (got.plan !== exp_w.plan || got.drop_level !== exp_w.drop_level ||
          got.stale !== exp_w.stale) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("ERROR: word %0d: plan %0d/%0d drop %0d/%0d stale %0d/%0d (exp/got)",
                   checked, exp_w.plan, got.plan, exp_w.drop_level, got.drop_level,
                   exp_w.stale, got.stale);
      end
    endfunction

    function int unsigned pending();
      return drop_results_q.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  gvdc_in_t             in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  gvdc_out_t            out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = CFG_BAND_LOW;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  drop_scoreboard sb;
  bit             idle_en = 1'b0;
  int unsigned    stall_left = 0;
  int unsigned    cycles = 0;
  int unsigned    words_sent = 0;
  int unsigned    settings = 0;
  int unsigned    level = 2000;
  int unsigned    run_left = 0;
  logic           cur_hold = 1'b1;

  gap_voltage_drop_classifier #(
    .WINDOW_LEN (WIN_LEN)
  ) u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_gap_voltage_drop_classifier NOT OK");
      $finish;
    end
  end

  // Receiver side: random stall bursts while idling is enabled.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (idle_en && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(1, 12) - 1;
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.predict_word(in_data);
      if (out_valid && !out_stall) sb.check_word(out_data);
    end
  end

  function automatic gvdc_in_t make_word(logic cmd, logic [READING_W-1:0] a,
                                         logic [READING_W-1:0] b, logic hold);
    gvdc_in_t w;
    w.cmd            = cmd;
    w.reading_a      = a;
    w.reading_b      = b;
    w.hold_reference = hold;
    return w;
  endfunction

  task automatic send_word(input gvdc_in_t w);
    int unsigned gap;
    if (idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // All three registers are written back to back with the enable held high.
  task automatic write_regs(input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi,
                            input logic [CFG_W-1:0] lim);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_BAND_LOW;
    cfg_wdata <= lo;
    sb.write_reg(CFG_BAND_LOW, lo);
    @(posedge clk);
    cfg_idx   <= CFG_BAND_HIGH;
    cfg_wdata <= hi;
    sb.write_reg(CFG_BAND_HIGH, hi);
    @(posedge clk);
    cfg_idx   <= CFG_STALE_LIM;
    cfg_wdata <= lim;
    sb.write_reg(CFG_STALE_LIM, lim);
    @(posedge clk);
    cfg_we <= 1'b0;
    settings++;
  endtask

  // Tracking runs fill the window at a level, then held runs sag below it so
  // the drop sweeps through the band. A few words break the pattern.
  task automatic next_random_word(output gvdc_in_t w);
    int unsigned r;
    int          a_v;
    int          b_v;
    if (run_left == 0) begin
      cur_hold = ~cur_hold;
      if (!cur_hold) begin
        level    = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                               : $urandom_range(1500, 4095);
        run_left = $urandom_range(8, 16);
      end else begin
        level    = level * $urandom_range(40, 100) / 100;
        run_left = $urandom_range(4, 24);
      end
    end
    run_left--;
    r = $urandom_range(0, 99);
    w.cmd            = (r >= 20);
    w.hold_reference = ($urandom_range(0, 19) == 0) ? ~cur_hold : cur_hold;
    if (r < 20 || r >= 90) begin
      w.reading_a = READING_W'($urandom);
      w.reading_b = READING_W'($urandom);
    end else begin
      a_v = int'(level) + int'($urandom_range(0, 63)) - 32;
      b_v = int'(level) + int'($urandom_range(0, 63)) - 32;
      a_v = (a_v < 0) ? 0 : (a_v > 4095) ? 4095 : a_v;
      b_v = (b_v < 0) ? 0 : (b_v > 4095) ? 4095 : b_v;
      w.reading_a = READING_W'(a_v);
      w.reading_b = READING_W'(b_v);
    end
  endtask

  initial begin
    gvdc_in_t    w;
    int unsigned lo;
    int unsigned hi;
    int unsigned lim;
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: zero reference, extreme readings, average above the
    // reference, then a held reference while the average falls through the
    // low edge, the band middle, the high edge and above the band.
    send_word(make_word(1'b0, 12'd0, 12'd0, 1'b0));
    send_word(make_word(1'b1, 12'd0, 12'd0, 1'b0));
    send_word(make_word(1'b1, 12'd4095, 12'd4095, 1'b0));
    send_word(make_word(1'b1, 12'd4095, 12'd0, 1'b1));
    for (int i = 0; i < 8; i++) send_word(make_word(1'b1, 12'd4000, 12'd4000, 1'b0));
    for (int i = 0; i < 8; i++) send_word(make_word(1'b1, 12'd3200, 12'd3200, 1'b1));
    send_word(make_word(1'b1, 12'd0, 12'd0, 1'b1));
    send_word(make_word(1'b1, 12'd0, 12'd0, 1'b1));
    // A zero stale limit makes one tick stale; a raised low edge puts the
    // stale drop below the band.
    wait_idle();
    write_regs(16'd25600, 16'd25600, 16'd0);
    send_word(make_word(1'b0, 12'd4095, 12'd4095, 1'b1));
    send_word(make_word(1'b1, 12'd2000, 12'd2001, 1'b1));

    for (int p = 0; p < PHASE_COUNT; p++) begin
      case (p)
        0: begin lo = BAND_LOW_RST; hi = BAND_HIGH_RST; lim = STALE_LIM_RST; end
        1: begin lo = 0; hi = 0; lim = 0; end
        2: begin lo = 25600; hi = 25600; lim = 65535; end
        3: begin
          lo  = $urandom_range(4000, 12000);
          hi  = $urandom_range(0, lo - 1);
          lim = $urandom_range(0, 6);
        end
        default: begin
          lo  = $urandom_range(0, 6000);
          hi  = lo + $urandom_range(500, 9000);
          lim = $urandom_range(0, 6);
        end
      endcase
      wait_idle();
      write_regs(CFG_W'(lo), CFG_W'(hi), CFG_W'(lim));
      idle_en = (p != PHASE_COUNT - 1);
      for (int i = 0; i < PHASE_WORDS; i++) begin
        if (p == 3 && i == PHASE_WORDS / 2) wait_idle();
        next_random_word(w);
        send_word(w);
      end
    end

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("Sent %0d words (%0d reading pairs, %0d ticks) over %0d register settings,",
             words_sent, sb.readings, sb.ticks, settings);
    $display("with window wrap, held reference and inverted bands; %0d checked, %0d failures.",
             sb.checked, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_gap_voltage_drop_classifier OK");
    end else begin
      $display("tb_gap_voltage_drop_classifier NOT OK");
    end
    $finish;
  end

endmodule

// File: gap_voltage_drop_classifier.f
sv/gvdc_pkg.sv
sv/gvdc_ram.sv
sv/gvdc_div.sv
sv/gap_voltage_drop_classifier.sv
tb/tb_gap_voltage_drop_classifier.sv
